### hw/rtl/rau_pkg.sv
// Package for the rational arithmetic unit: operation and status codes,
// the request kind passed from front to back, and default widths.
// No dependencies.
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int MAG_BITS      = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_GT  = 3'd4;
    localparam logic [2:0] OP_EQ  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        K_ARITH,
        K_COMPARE,
        K_FIXED
    } kind_t;

endpackage

### hw/rtl/rau_front.sv
// Front end of the rational arithmetic unit: accepts a request, unpacks the
// operands to sign-magnitude and screens the special cases.
// Depends on rau_pkg.
module rau_front #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           operation,
    input  logic signed [31:0]   a_num,
    input  logic signed [31:0]   a_den,
    input  logic signed [31:0]   b_num,
    input  logic signed [31:0]   b_den,
    output logic                 q_valid,
    input  logic                 q_take,
    output logic [2:0]           q_op,
    output rau_pkg::kind_t       q_kind,
    output logic [1:0]           q_status,
    output logic [4*(WORD_BITS+1)-1:0] q_mags,
    output logic [3:0]           q_negs
);
    import rau_pkg::*;

    localparam int MW = WORD_BITS + 1;
    localparam int DEPTH = 2;

    logic [MW-1:0] mag [4];
    logic [3:0]    neg;
    logic [WORD_BITS-1:0] raw [4];
    kind_t         kind;
    logic [1:0]    st;

    logic [2:0]    op_mem [DEPTH];
    kind_t         kind_mem [DEPTH];
    logic [1:0]    st_mem [DEPTH];
    logic [4*MW-1:0] mag_mem [DEPTH];
    logic [3:0]    neg_mem [DEPTH];
    logic          wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          acc;

    assign raw[0] = a_num[WORD_BITS-1:0];
    assign raw[1] = a_den[WORD_BITS-1:0];
    assign raw[2] = b_num[WORD_BITS-1:0];
    assign raw[3] = b_den[WORD_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg[i] = raw[i][WORD_BITS-1];
            mag[i] = neg[i] ? ((MW'(1) << WORD_BITS) - {1'b0, raw[i]})
                            : {1'b0, raw[i]};
        end
        st   = ST_OK;
        kind = K_ARITH;
        if (operation > OP_EQ)
            kind = K_FIXED;
        else if (mag[1] == '0 || mag[3] == '0 || (operation == OP_DIV && mag[2] == '0))
        begin
            kind = K_FIXED;
            st   = ST_ZERO_DEN;
        end
        else if (operation == OP_GT || operation == OP_EQ)
            kind = K_COMPARE;
    end

    assign full = (cnt_reg == 2'(DEPTH));
    assign acc  = push && !full;
    assign q_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        wr_next  = acc ? !wr_reg : wr_reg;
        rd_next  = (q_take && q_valid) ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(acc) - 2'(q_take && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_mem[wr_reg]   <= operation;
            kind_mem[wr_reg] <= kind;
            st_mem[wr_reg]   <= st;
            mag_mem[wr_reg]  <= {mag[3], mag[2], mag[1], mag[0]};
            neg_mem[wr_reg]  <= neg;
        end
    end

    assign q_op     = op_mem[rd_reg];
    assign q_kind   = kind_mem[rd_reg];
    assign q_status = st_mem[rd_reg];
    assign q_mags   = mag_mem[rd_reg];
    assign q_negs   = neg_mem[rd_reg];

endmodule

### hw/rtl/rau_back.sv
// Back end of the rational arithmetic unit: cross products, sum, binary
// long division for gcd and reduction, range check and one result register.
// Depends on rau_pkg.
module rau_back #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_take,
    input  logic [2:0]           q_op,
    input  rau_pkg::kind_t       q_kind,
    input  logic [1:0]           q_status,
    input  logic [4*(WORD_BITS+1)-1:0] q_mags,
    input  logic [3:0]           q_negs,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   res_num,
    output logic [30:0]          res_den,
    output logic                 compare_true,
    output logic [1:0]           status
);
    import rau_pkg::*;

    localparam int MW = WORD_BITS + 1;
    localparam int CW = $clog2(MAG_BITS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_GCD  = 4'd5;
    localparam logic [3:0] S_DIVN = 4'd6;
    localparam logic [3:0] S_DIVD = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;

    logic [3:0]  state_reg, state_next, ret_reg, ret_next;
    logic [2:0]  op_reg;
    logic [MW-1:0] m_reg [4];
    logic [3:0]  ng_reg;
    logic [MAG_BITS-1:0] p0_reg, p1_reg, pd_reg;
    logic        n0_reg, n1_reg, nd_reg;
    logic [MAG_BITS-1:0] gx_reg, gy_reg, g_reg;
    logic [MAG_BITS-1:0] dvd_reg, quo_reg, rem_reg, qn_reg;
    logic [CW-1:0] cnt_reg;
    logic        nn_reg;
    logic        full_reg;
    logic signed [31:0] rn_reg;
    logic [30:0] rd_reg;
    logic        ct_reg;
    logic [1:0]  st_reg;
    logic signed [31:0] res_num_reg;
    logic [30:0] res_den_reg;
    logic        res_cmp_reg;
    logic [1:0]  res_st_reg;

    logic [MW-1:0] fa, fb;
    logic [MAG_BITS-1:0] prod;
    logic [MAG_BITS:0]   trial;
    logic [MAG_BITS-1:0] rem_sh;
    logic        yneg;
    logic [MAG_BITS-1:0] sum_mag;
    logic        sum_neg;
    logic [MAG_BITS-1:0] lim;
    logic        rneg;

    assign empty = !full_reg;
    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign compare_true = res_cmp_reg;
    assign status = res_st_reg;
    assign q_take = (state_reg == S_IDLE) && q_valid;
    assign lim = (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(1);

    always_comb
    begin
        fa = m_reg[0];
        fb = m_reg[3];
        case (state_reg)
            S_MUL1:  begin fa = m_reg[0]; fb = (op_reg == OP_MUL) ? m_reg[2] : m_reg[3]; end
            S_MUL2:  begin fa = m_reg[2]; fb = m_reg[1]; end
            S_MUL3:  begin fa = m_reg[1]; fb = (op_reg == OP_DIV) ? m_reg[2] : m_reg[3]; end
            default: begin fa = m_reg[0]; fb = m_reg[3]; end
        endcase
        prod   = MAG_BITS'(fa) * MAG_BITS'(fb);
        rem_sh = {rem_reg[MAG_BITS-2:0], dvd_reg[MAG_BITS-1]};
        trial  = {1'b0, rem_sh} - {1'b0, g_reg};
        yneg   = (op_reg == OP_ADD) ? n1_reg : !n1_reg;
        if (n0_reg == yneg)
        begin
            sum_mag = p0_reg + p1_reg;
            sum_neg = n0_reg;
        end
        else if (p0_reg >= p1_reg)
        begin
            sum_mag = p0_reg - p1_reg;
            sum_neg = n0_reg && (p0_reg != p1_reg);
        end
        else
        begin
            sum_mag = p1_reg - p0_reg;
            sum_neg = yneg;
        end
        rneg   = (qn_reg != '0) && (nn_reg != nd_reg);
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:  if (q_valid)
                         state_next = (q_kind == K_FIXED) ? S_OUT : S_MUL1;
            S_MUL1:  state_next = (op_reg == OP_MUL || op_reg == OP_DIV) ? S_MUL3 : S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_SUM;
            S_SUM:   state_next = (op_reg == OP_GT || op_reg == OP_EQ) ? S_FIN : S_GCD;
            S_GCD:   begin
                         state_next = S_DIV;
                         ret_next   = (gy_reg == '0) ? S_DIVN : S_GCD;
                     end
            S_DIVN:  begin state_next = S_DIV; ret_next = S_DIVD; end
            S_DIVD:  state_next = S_FIN;
            S_DIV:   if (cnt_reg == CW'(1)) state_next = ret_reg;
            S_FIN:   state_next = S_OUT;
            S_OUT:   if (!full_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (state_reg == S_OUT && !full_reg)
                full_reg <= 1'b1;
            else if (pop && full_reg)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && !full_reg)
        begin
            res_num_reg <= rn_reg;
            res_den_reg <= rd_reg;
            res_cmp_reg <= ct_reg;
            res_st_reg  <= st_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg <= q_op;
                for (int i = 0; i < 4; i++)
                    m_reg[i] <= q_mags[i*MW +: MW];
                ng_reg <= q_negs;
                st_reg <= q_status;
                rn_reg <= '0;
                rd_reg <= '0;
                ct_reg <= 1'b0;
            end
            S_MUL1:
            begin
                p0_reg <= prod;
                n0_reg <= (prod != '0) &&
                          (ng_reg[0] != ((op_reg == OP_MUL) ? ng_reg[2] : ng_reg[3]));
                p1_reg <= '0;
                n1_reg <= 1'b0;
            end
            S_MUL2:
            begin
                p1_reg <= prod;
                n1_reg <= (prod != '0) && (ng_reg[2] != ng_reg[1]);
            end
            S_MUL3:
            begin
                pd_reg <= prod;
                nd_reg <= (prod != '0) &&
                          (ng_reg[1] != ((op_reg == OP_DIV) ? ng_reg[2] : ng_reg[3]));
            end
            S_SUM:
            begin
                gx_reg <= sum_mag;
                p0_reg <= sum_mag;
                nn_reg <= sum_neg;
                gy_reg <= pd_reg;
            end
            S_GCD:
            begin
                if (gy_reg == '0)
                begin
                    g_reg   <= gx_reg;
                    dvd_reg <= p0_reg;
                end
                else
                begin
                    g_reg   <= gy_reg;
                    dvd_reg <= gx_reg;
                    gx_reg  <= gy_reg;
                end
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CW'(MAG_BITS);
            end
            S_DIVN:
            begin
                qn_reg  <= quo_reg;
                dvd_reg <= pd_reg;
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= CW'(MAG_BITS);
            end
            S_DIVD:
            begin
                pd_reg  <= quo_reg;
            end
            S_DIV:
            begin
                dvd_reg <= {dvd_reg[MAG_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - CW'(1);
                if (!trial[MAG_BITS])
                begin
                    rem_reg <= trial[MAG_BITS-1:0];
                    quo_reg <= {quo_reg[MAG_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[MAG_BITS-2:0], 1'b0};
                end
                if (cnt_reg == CW'(1) && ret_reg == S_GCD)
                begin
                    gy_reg <= trial[MAG_BITS] ? rem_sh : trial[MAG_BITS-1:0];
                end
            end
            S_FIN:
            begin
                if (op_reg == OP_GT || op_reg == OP_EQ)
                begin
                    ct_reg <= (op_reg == OP_EQ) ? (p0_reg == '0)
                                                : ((p0_reg != '0) && (nn_reg == nd_reg));
                end
                else if (pd_reg > lim || (rneg ? (qn_reg > lim + MAG_BITS'(1))
                                               : (qn_reg > lim)))
                    st_reg <= ST_OVERFLOW;
                else
                begin
                    rn_reg <= 32'(signed'(WORD_BITS'(rneg ? (MAG_BITS'(0) - qn_reg)
                                                          : qn_reg)));
                    rd_reg <= 31'(pd_reg);
                end
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: front end, request queue and back end.
// Depends on rau_pkg, rau_front, rau_back.
//
//   channel   | handshake     | ports
//   request   | push / full   | operation a_num a_den b_num b_den
//   result    | empty / pop   | res_num res_den compare_true status
//
// An arithmetic request runs cross products, a gcd by repeated division and
// reduction on a bit-serial 64-step divider; multiply and divide skip one
// product. A compare stops after the sum, and a screened request (error, unused
// code) goes straight to the result. Reset empties the queue and the result register.
// A waiting result holds the back end only at its hand-off step; the queue holds two requests.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         operation,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic               compare_true,
    output logic [1:0]         status
);
    import rau_pkg::*;

    logic        q_valid, q_take;
    logic [2:0]  q_op;
    kind_t       q_kind;
    logic [1:0]  q_status;
    logic [4*(WORD_BITS+1)-1:0] q_mags;
    logic [3:0]  q_negs;

    rau_front #(.WORD_BITS(WORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .a_num(a_num), .a_den(a_den),
        .b_num(b_num), .b_den(b_den),
        .q_valid(q_valid), .q_take(q_take), .q_op(q_op), .q_kind(q_kind),
        .q_status(q_status), .q_mags(q_mags), .q_negs(q_negs)
    );

    rau_back #(.WORD_BITS(WORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_take(q_take), .q_op(q_op), .q_kind(q_kind),
        .q_status(q_status), .q_mags(q_mags), .q_negs(q_negs),
        .empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den),
        .compare_true(compare_true), .status(status)
    );

endmodule

### tb/sv/rau_checker.sv
// Checker for the rational arithmetic unit: watches the request and result
// queues, predicts each result from the request fields and compares them.
// Depends on rau_pkg for operation and status codes.
module rau_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [2:0]         operation,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] res_num,
    input  logic [30:0]        res_den,
    input  logic               compare_true,
    input  logic [1:0]         status,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               cmp;
        logic [1:0]         st;
    } fraction_result_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } signed_mag_t;

    fraction_result_t awaited_results[$];

    function automatic signed_mag_t split_word(logic signed [31:0] w);
        signed_mag_t r;
        longint v;
        v = w;
        r.neg = v < 0;
        r.mag = r.neg ? -v : v;
        return r;
    endfunction

    function automatic signed_mag_t times(signed_mag_t x, signed_mag_t y);
        signed_mag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic signed_mag_t plus(signed_mag_t x, signed_mag_t y, logic sub);
        signed_mag_t r;
        logic yneg;
        yneg = sub ? !y.neg : y.neg;
        if (x.neg == yneg)
        begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end
        else if (x.mag >= y.mag)
        begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end
        else
        begin
            r.mag = y.mag - x.mag;
            r.neg = yneg;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic fraction_result_t reduce_fraction(logic [2:0] op,
        logic signed [31:0] an_w, logic signed [31:0] ad_w,
        logic signed [31:0] bn_w, logic signed [31:0] bd_w);
        fraction_result_t r;
        signed_mag_t an, ad, bn, bd, n, d, diff, dp;
        logic [63:0] x, y, t, nm, dm;
        logic neg;
        r = '0;
        an = split_word(an_w);
        ad = split_word(ad_w);
        bn = split_word(bn_w);
        bd = split_word(bd_w);
        if (op > OP_EQ)
            return r;
        if (ad.mag == 0 || bd.mag == 0 || (op == OP_DIV && bn.mag == 0))
        begin
            r.st = ST_ZERO_DEN;
            return r;
        end
        if (op == OP_GT || op == OP_EQ)
        begin
            diff = plus(times(an, bd), times(bn, ad), 1'b1);
            dp = times(ad, bd);
            if (op == OP_GT)
                r.cmp = (diff.mag != 0) && (diff.neg == dp.neg);
            else
                r.cmp = (diff.mag == 0);
            return r;
        end
        case (op)
            OP_ADD, OP_SUB:
            begin
                n = plus(times(an, bd), times(bn, ad), op == OP_SUB);
                d = times(ad, bd);
            end
            OP_MUL:
            begin
                n = times(an, bn);
                d = times(ad, bd);
            end
            default:
            begin
                n = times(an, bd);
                d = times(ad, bn);
            end
        endcase
        x = n.mag;
        y = d.mag;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = n.mag / x;
        dm = d.mag / x;
        neg = (nm != 0) && (n.neg != d.neg);
        if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF))
        begin
            r.st = ST_OVERFLOW;
            return r;
        end
        r.num = neg ? -nm[31:0] : nm[31:0];
        r.den = dm[30:0];
        return r;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        fraction_result_t exp_r;
        if (rst_n)
        begin
            if (push && !full)
                awaited_results.push_back(reduce_fraction(operation, a_num, a_den,
                                                          b_num, b_den));
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result num=%0d den=%0d cmp=%0b st=%0d",
                             $time, res_num, res_den, compare_true, status);
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (exp_r.num !== res_num)
                    begin
                        errors++;
                        $display("%0t: res_num expected %0d actual %0d",
                                 $time, exp_r.num, res_num);
                    end
                    if (exp_r.den !== res_den)
                    begin
                        errors++;
                        $display("%0t: res_den expected %0d actual %0d",
                                 $time, exp_r.den, res_den);
                    end
                    if (exp_r.cmp !== compare_true)
                    begin
                        errors++;
                        $display("%0t: compare_true expected %0b actual %0b",
                                 $time, exp_r.cmp, compare_true);
                    end
                    if (exp_r.st !== status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.st, status);
                    end
                end
            end
            pending = awaited_results.size();
        end
    end
endmodule

### tb/sv/tb_top.sv
// Testbench top for the rational arithmetic unit: clock, reset, directed and
// random requests under several idle and stall patterns, watchdog and verdict.
// Depends on rau_pkg, rational_arithmetic_unit and rau_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic [2:0]         operation = '0;
    logic signed [31:0] a_num = '0;
    logic signed [31:0] a_den = '0;
    logic signed [31:0] b_num = '0;
    logic signed [31:0] b_den = '0;
    logic               full;
    logic               empty;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic [1:0]         status;
    int                 errors;
    int                 pending;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    logic               hold_pop = 1'b0;
    int                 quiet_cycles = 0;

    localparam int WATCHDOG_LIMIT = 200000;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rational_arithmetic_unit uut (.*);

    rau_checker checker_i (.*);

    always @(posedge clk)
    begin
        if (rst_n)
            pop <= !hold_pop && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rational_arithmetic_unit");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] op, logic signed [31:0] an,
                                logic signed [31:0] ad, logic signed [31:0] bn,
                                logic signed [31:0] bd);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        operation <= op;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        do
            @(posedge clk);
        while (full);
    endtask

    function automatic logic signed [31:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $signed($urandom_range(128)) - 64;
        if (sel < 80)
            case ($urandom_range(4))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd1;
                3: return -32'sd1;
                default: return 32'sd0;
            endcase
        return $urandom;
    endfunction

    task automatic random_requests(int count);
        logic [2:0] op;
        repeat (count)
        begin
            op = ($urandom_range(99) < 4) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
            send_request(op, pick_word(), pick_word(), pick_word(), pick_word());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
        send_request(OP_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
        send_request(OP_MUL, -32'sd3, 32'sd4, 32'sd8, -32'sd9);
        send_request(OP_DIV, 32'sd5, 32'sd7, -32'sd10, 32'sd21);
        send_request(OP_GT, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
        send_request(OP_GT, -32'sd1, 32'sd2, 32'sd1, -32'sd3);
        send_request(OP_EQ, 32'sd1, 32'sd2, 32'sd2, 32'sd4);
        send_request(OP_EQ, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
        send_request(OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1);
        send_request(OP_EQ, 32'sd1, 32'sd1, 32'sd1, 32'sd0);
        send_request(OP_DIV, 32'sd1, 32'sd1, 32'sd0, 32'sd5);
        send_request(OP_ADD, 32'sh7FFF_FFFF, 32'sd1, 32'sd1, 32'sd1);
        send_request(OP_SUB, 32'sh8000_0000, 32'sd1, 32'sd1, 32'sd1);
        send_request(OP_MUL, 32'sh8000_0000, 32'sd1, 32'sd1, 32'sd1);
        send_request(OP_MUL, 32'sh8000_0000, 32'sd1, -32'sd1, 32'sd1);
        send_request(OP_DIV, 32'sd1, 32'sh8000_0000, 32'sd1, 32'sd1);
        send_request(OP_DIV, 32'sd1, 32'sh7FFF_FFFF, 32'sd1, 32'sh7FFF_FFFF);
        send_request(OP_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh7FFF_FFFF);
        send_request(OP_ADD, 32'sd0, -32'sd7, 32'sd0, 32'sd3);
        send_request(OP_GT, 32'sh7FFF_FFFF, 32'sd1, 32'sh8000_0000, 32'sd1);
        send_request(3'd6, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        send_request(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

        random_requests(400);
        idle_pct = 72;
        random_requests(400);
        idle_pct = 0;
        stall_pct = 72;
        random_requests(400);
        idle_pct = 36;
        stall_pct = 36;
        random_requests(400);

        idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_pop = 1'b1;
                repeat (20000) @(posedge clk);
                hold_pop = 1'b0;
            end
            random_requests(300);
        join
        push <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS rational_arithmetic_unit");
        else
            $display("FAIL rational_arithmetic_unit");
        $finish;
    end
endmodule
